/* rtl/sgac_pkg.sv */
package sgac_pkg;

  typedef enum logic [1:0] {
    ST_IDLE    = 2'd0,
    ST_ACTIVE  = 2'd1,
    ST_PAUSED  = 2'd2,
    ST_STOPPED = 2'd3
  } rec_state_t;

  typedef enum logic [1:0] {
    EV_NONE    = 2'd0,
    EV_STARTED = 2'd1,
    EV_STOPPED = 2'd2,
    EV_REFUSED = 2'd3
  } event_t;

  typedef enum logic [2:0] {
    MODE_SAMPLE = 3'd0,
    MODE_SPEED  = 3'd1,
    MODE_START  = 3'd2,
    MODE_STOP   = 3'd3,
    MODE_PAUSE  = 3'd4,
    MODE_RESUME = 3'd5
  } mode_t;

  typedef enum logic [2:0] {
    CFG_AUTO_ENABLE = 3'd0,
    CFG_START_SPEED = 3'd1,
    CFG_STOP_SPEED  = 3'd2,
    CFG_STOP_DELAY  = 3'd3,
    CFG_MAX_DUR     = 3'd4,
    CFG_MIN_FREE    = 3'd5
  } cfg_index_t;

  localparam logic        RST_AUTO_ENABLE = 1'b1;
  localparam logic [11:0] RST_START_SPEED = 12'd100;
  localparam logic [11:0] RST_STOP_SPEED  = 12'd50;
  localparam logic [31:0] RST_STOP_DELAY  = 32'd30000;
  localparam logic [31:0] RST_MAX_DUR     = 32'd3600000;
  localparam logic [23:0] RST_MIN_FREE    = 24'd50000;

  localparam logic [7:0]  VOL_CENTER      = 8'd128;

  typedef struct packed {
    logic        auto_record_enable;
    logic [11:0] start_speed_tenths;
    logic [11:0] stop_speed_tenths;
    logic [31:0] stop_hold_ms;
    logic [31:0] max_duration_ms;
    logic [23:0] min_free_bytes;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  mode;
    logic [11:0] adc_sample;
    logic        speed_valid;
    logic [11:0] speed_tenths;
    logic [31:0] now_ms;
    logic [23:0] free_bytes;
  } item_t;

  typedef struct packed {
    logic [1:0]  rec_status;
    logic [1:0]  event_res;
    logic        sample_taken;
    logic [7:0]  sample_byte;
    logic        block_full;
    logic [8:0]  leftover_count;
    logic [7:0]  volume_level;
    logic [7:0]  volume_max;
    logic [31:0] sample_count;
    logic [31:0] take_ms;
    logic        error_flag;
  } result_t;

endpackage

/* rtl/sgac_cfg.sv */
module sgac_cfg
  import sgac_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output cfg_t        cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.auto_record_enable <= RST_AUTO_ENABLE;
      cfg.start_speed_tenths <= RST_START_SPEED;
      cfg.stop_speed_tenths  <= RST_STOP_SPEED;
      cfg.stop_hold_ms       <= RST_STOP_DELAY;
      cfg.max_duration_ms    <= RST_MAX_DUR;
      cfg.min_free_bytes     <= RST_MIN_FREE;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_AUTO_ENABLE: cfg.auto_record_enable <= cfg_data[0];
        CFG_START_SPEED: cfg.start_speed_tenths <= cfg_data[11:0];
        CFG_STOP_SPEED:  cfg.stop_speed_tenths  <= cfg_data[11:0];
        CFG_STOP_DELAY:  cfg.stop_hold_ms       <= cfg_data;
        CFG_MAX_DUR:     cfg.max_duration_ms    <= cfg_data;
        CFG_MIN_FREE:    cfg.min_free_bytes     <= cfg_data[23:0];
        default: begin
        end
      endcase
    end
  end

endmodule

/* rtl/sgac_core.sv */
module sgac_core
  import sgac_pkg::*;
#(
  parameter int BUFFER_BYTES = 512
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    take,
  input  item_t   item,
  input  cfg_t    cfg,
  output result_t result
);

  localparam int FW = $clog2(BUFFER_BYTES);
  localparam logic [FW:0] BUF_LIM = BUFFER_BYTES[FW:0];

  rec_state_t    rec_state, rec_state_next;
  logic [FW-1:0] fill_index, fill_index_next;
  logic [31:0]   sample_total, sample_total_next;
  logic [31:0]   take_start, take_start_next;
  logic [31:0]   elapsed, elapsed_next;
  logic [7:0]    volume_now, volume_now_next;
  logic [7:0]    volume_peak, volume_peak_next;
  logic          waiting_stop, waiting_stop_next;
  logic [31:0]   low_speed_since, low_speed_since_next;
  logic          error_seen, error_seen_next;

  logic [11:0]   cur_speed;
  logic [31:0]   el_now;
  logic [31:0]   low_time;
  logic [FW:0]   fill_inc;
  logic [7:0]    byte_v;
  logic          start_req;
  logic          stop_req;
  event_t        ev;
  logic          taken;
  logic          full;
  logic [8:0]    leftover;

  assign cur_speed = item.speed_valid ? item.speed_tenths : 12'd0;
  assign el_now    = item.now_ms - take_start;
  assign low_time  = item.now_ms - low_speed_since;
  assign fill_inc  = {1'b0, fill_index} + {{FW{1'b0}}, 1'b1};
  assign byte_v    = item.adc_sample[11:4];

  always_comb begin
    rec_state_next       = rec_state;
    fill_index_next      = fill_index;
    sample_total_next    = sample_total;
    take_start_next      = take_start;
    elapsed_next         = elapsed;
    volume_now_next      = volume_now;
    volume_peak_next     = volume_peak;
    waiting_stop_next    = waiting_stop;
    low_speed_since_next = low_speed_since;
    error_seen_next      = error_seen;
    start_req            = 1'b0;
    stop_req             = 1'b0;
    ev                   = EV_NONE;
    taken                = 1'b0;
    full                 = 1'b0;
    leftover             = 9'd0;

    case (item.mode)
      MODE_SAMPLE: begin
        if (rec_state == ST_ACTIVE) begin
          taken           = 1'b1;
          volume_now_next = byte_v[7] ? (byte_v - VOL_CENTER) : (VOL_CENTER - byte_v);
          if (volume_now_next > volume_peak) volume_peak_next = volume_now_next;
          sample_total_next = sample_total + 32'd1;
          if (fill_inc >= BUF_LIM) begin
            full            = 1'b1;
            fill_index_next = '0;
          end else begin
            fill_index_next = fill_inc[FW-1:0];
          end
          elapsed_next = el_now;
          if (el_now > cfg.max_duration_ms) stop_req = 1'b1;
        end
      end
      MODE_SPEED: begin
        if (cfg.auto_record_enable) begin
          if (rec_state == ST_IDLE || rec_state == ST_STOPPED) begin
            if (cur_speed >= cfg.start_speed_tenths) start_req = 1'b1;
          end else if (rec_state == ST_ACTIVE) begin
            if (cur_speed < cfg.stop_speed_tenths) begin
              if (!waiting_stop) begin
                waiting_stop_next    = 1'b1;
                low_speed_since_next = item.now_ms;
              end else if (low_time > cfg.stop_hold_ms) begin
                stop_req = 1'b1;
              end
            end else begin
              waiting_stop_next = 1'b0;
            end
          end
        end
      end
      MODE_START: start_req = 1'b1;
      MODE_STOP:  stop_req  = 1'b1;
      MODE_PAUSE: begin
        if (rec_state == ST_ACTIVE) rec_state_next = ST_PAUSED;
      end
      MODE_RESUME: begin
        if (rec_state == ST_PAUSED) rec_state_next = ST_ACTIVE;
      end
      default: begin
      end
    endcase

    // start and stop requests never come from the same item
    if (start_req && rec_state != ST_ACTIVE) begin
      if (item.free_bytes < cfg.min_free_bytes) begin
        error_seen_next = 1'b1;
        ev              = EV_REFUSED;
      end else begin
        sample_total_next = '0;
        take_start_next   = item.now_ms;
        elapsed_next      = '0;
        volume_peak_next  = '0;
        error_seen_next   = 1'b0;
        fill_index_next   = '0;
        waiting_stop_next = 1'b0;
        rec_state_next    = ST_ACTIVE;
        ev                = EV_STARTED;
      end
    end

    if (stop_req && (rec_state == ST_ACTIVE || rec_state == ST_PAUSED)) begin
      leftover        = 9'(fill_index_next);
      fill_index_next = '0;
      rec_state_next  = ST_STOPPED;
      elapsed_next    = el_now;
      ev              = EV_STOPPED;
    end
  end

  always_comb begin
    result.rec_status     = rec_state_next;
    result.event_res      = ev;
    result.sample_taken   = taken;
    result.sample_byte    = taken ? byte_v : 8'd0;
    result.block_full     = full;
    result.leftover_count = leftover;
    result.volume_level   = volume_now_next;
    result.volume_max     = volume_peak_next;
    result.sample_count   = sample_total_next;
    result.take_ms        = elapsed_next;
    result.error_flag     = error_seen_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rec_state       <= ST_IDLE;
      fill_index      <= '0;
      sample_total    <= '0;
      take_start      <= '0;
      elapsed         <= '0;
      volume_now      <= '0;
      volume_peak     <= '0;
      waiting_stop    <= 1'b0;
      low_speed_since <= '0;
      error_seen      <= 1'b0;
    end else if (take) begin
      rec_state       <= rec_state_next;
      fill_index      <= fill_index_next;
      sample_total    <= sample_total_next;
      take_start      <= take_start_next;
      elapsed         <= elapsed_next;
      volume_now      <= volume_now_next;
      volume_peak     <= volume_peak_next;
      waiting_stop    <= waiting_stop_next;
      low_speed_since <= low_speed_since_next;
      error_seen      <= error_seen_next;
    end
  end

endmodule

/* rtl/speed_gated_audio_capture_control.sv */
// Channel  | Handshake                     | Payload
// ---------+-------------------------------+------------------------------------------
// input    | in_valid / in_stall           | mode, adc_sample, speed_valid,
//          |                               | speed_tenths, now_ms, free_bytes
// output   | out_valid / out_stall         | rec_status ... error_flag (11 fields)
// config   | cfg_write, cfg_index          | cfg_data (32 bits, truncated per register)
//
// One item per clock while in_stall is low. An accepted item updates the recorder
// state and the result register at the same edge; the result shows the next cycle.
// The state update (a 32-bit subtract and compare on the time paths) is the
// only logic between the input ports and the result register.
// rst is synchronous: recorder idle, counters zero, registers at their defaults.
// in_stall is high only while a result waits and out_stall holds it.
module speed_gated_audio_capture_control
  import sgac_pkg::*;
#(
  parameter int BUFFER_BYTES = 512
) (
  input  logic        clk,
  input  logic        rst,

  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  mode,
  input  logic [11:0] adc_sample,
  input  logic        speed_valid,
  input  logic [11:0] speed_tenths,
  input  logic [31:0] now_ms,
  input  logic [23:0] free_bytes,

  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  rec_status,
  output logic [1:0]  event_res,
  output logic        sample_taken,
  output logic [7:0]  sample_byte,
  output logic        block_full,
  output logic [8:0]  leftover_count,
  output logic [7:0]  volume_level,
  output logic [7:0]  volume_max,
  output logic [31:0] sample_count,
  output logic [31:0] take_ms,
  output logic        error_flag,

  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  cfg_t    cfg;
  item_t   item;
  result_t result;
  result_t res_reg;
  logic    take;

  // Hold new items only while the result register is full and stalled.
  assign in_stall = out_valid & out_stall;
  assign take     = in_valid & ~in_stall;

  assign item.mode         = mode;
  assign item.adc_sample   = adc_sample;
  assign item.speed_valid  = speed_valid;
  assign item.speed_tenths = speed_tenths;
  assign item.now_ms       = now_ms;
  assign item.free_bytes   = free_bytes;

  sgac_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  sgac_core #(
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .take   (take),
    .item   (item),
    .cfg    (cfg),
    .result (result)
  );

  // Result register: load on accept, drop valid once the consumer takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res_reg <= result;
    end
  end

  assign rec_status     = res_reg.rec_status;
  assign event_res      = res_reg.event_res;
  assign sample_taken   = res_reg.sample_taken;
  assign sample_byte    = res_reg.sample_byte;
  assign block_full     = res_reg.block_full;
  assign leftover_count = res_reg.leftover_count;
  assign volume_level   = res_reg.volume_level;
  assign volume_max     = res_reg.volume_max;
  assign sample_count   = res_reg.sample_count;
  assign take_ms        = res_reg.take_ms;
  assign error_flag     = res_reg.error_flag;

  // Every accepted item leaves a result behind it.
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    take |=> out_valid)
    else $error("accepted item produced no result");

  // A recorded sample means the recorder is still active or was just stopped.
  a_sample_state: assert property (@(posedge clk) disable iff (rst)
    (out_valid && sample_taken) |->
      (rec_status == ST_ACTIVE || event_res == EV_STOPPED))
    else $error("sample recorded outside an active recording");

  // A fresh start clears the counters and the error flag.
  a_start_fresh: assert property (@(posedge clk) disable iff (rst)
    (out_valid && event_res == EV_STARTED) |->
      (rec_status == ST_ACTIVE && sample_count == 32'd0 && !error_flag))
    else $error("start did not produce a fresh recording");

  // A refused start raises the error flag.
  a_refuse_flag: assert property (@(posedge clk) disable iff (rst)
    (out_valid && event_res == EV_REFUSED) |-> error_flag)
    else $error("refused start left error flag low");

  // Buffer bytes are flushed only by a stop.
  a_leftover_stop: assert property (@(posedge clk) disable iff (rst)
    (out_valid && leftover_count != 9'd0) |->
      (event_res == EV_STOPPED && rec_status == ST_STOPPED))
    else $error("leftover count without a stop");

endmodule

/* sim/tb_speed_gated_audio_capture_control.sv */
module tb_speed_gated_audio_capture_control;
  import sgac_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int BUFFER_BYTES = 512;
  // Give up after this many cycles with no item moving on either channel.
  localparam int STALL_LIMIT = 400;

  // Mode codes the block must treat as no-ops.
  localparam logic [2:0] MODE_SPARE6 = 3'd6;
  localparam logic [2:0] MODE_SPARE7 = 3'd7;

  logic        clk;
  logic        rst;

  logic        in_valid;
  logic        in_stall;
  logic [2:0]  mode;
  logic [11:0] adc_sample;
  logic        speed_valid;
  logic [11:0] speed_tenths;
  logic [31:0] now_ms;
  logic [23:0] free_bytes;

  logic        out_valid;
  logic        out_stall;
  logic [1:0]  rec_status;
  logic [1:0]  event_res;
  logic        sample_taken;
  logic [7:0]  sample_byte;
  logic        block_full;
  logic [8:0]  leftover_count;
  logic [7:0]  volume_level;
  logic [7:0]  volume_max;
  logic [31:0] sample_count;
  logic [31:0] take_ms;
  logic        error_flag;

  logic        cfg_write;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;

  speed_gated_audio_capture_control #(.BUFFER_BYTES(BUFFER_BYTES)) u_dut (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Recorder shadow: our own copy of the controller state and its registers.
  // ---------------------------------------------------------------------------
  cfg_t        settings;
  rec_state_t  rec_now;
  logic [9:0]  fill_cnt;       // one bit wider than the port: counts up to the wrap
  logic [31:0] sample_cnt;
  logic [31:0] start_ms;
  logic [31:0] elapsed_ms;
  logic [31:0] low_since_ms;
  logic [7:0]  vol_now;
  logic [7:0]  vol_peak;
  logic        stop_armed;
  logic        refused;

  // Reports still owed by the block, oldest first.
  result_t     status_due[$];

  int          mismatches;
  int          idle_cycles;

  // Stimulus knobs, set per phase.
  int          sample_pct;
  int          stop_pct;
  int          dt_max;
  logic [31:0] t_ms;
  bit          tx_calm;
  bit          rx_calm;

  function automatic void shadow_reset();
    settings = '{RST_AUTO_ENABLE, RST_START_SPEED, RST_STOP_SPEED,
                 RST_STOP_DELAY, RST_MAX_DUR, RST_MIN_FREE};
    rec_now      = ST_IDLE;
    fill_cnt     = '0;
    sample_cnt   = '0;
    start_ms     = '0;
    elapsed_ms   = '0;
    low_since_ms = '0;
    vol_now      = '0;
    vol_peak     = '0;
    stop_armed   = 1'b0;
    refused      = 1'b0;
  endfunction

  // End a recording: flush the partial buffer count and freeze the duration.
  function automatic event_t close_take(input logic [31:0] now, output logic [8:0] left);
    left = '0;
    if (rec_now != ST_ACTIVE && rec_now != ST_PAUSED)
      return EV_NONE;
    left       = fill_cnt[8:0];
    fill_cnt   = '0;
    rec_now    = ST_STOPPED;
    elapsed_ms = now - start_ms;
    return EV_STOPPED;
  endfunction

  // Begin a fresh recording unless one is running or storage is short.
  function automatic event_t open_take(input logic [31:0] now, input logic [23:0] avail);
    if (rec_now == ST_ACTIVE)
      return EV_NONE;
    if (avail < settings.min_free_bytes) begin
      refused = 1'b1;
      return EV_REFUSED;
    end
    sample_cnt = '0;
    start_ms   = now;
    elapsed_ms = '0;
    vol_peak   = '0;
    refused    = 1'b0;
    fill_cnt   = '0;
    stop_armed = 1'b0;
    rec_now    = ST_ACTIVE;
    return EV_STARTED;
  endfunction

  // Advance the shadow by one item and return the report it should produce.
  function automatic result_t recorder_step(input item_t it);
    result_t     r;
    logic [11:0] cur;
    logic [7:0]  b;
    logic [8:0]  left;
    logic [31:0] lapse;
    r    = '0;
    left = '0;
    case (it.mode)
      MODE_SAMPLE: if (rec_now == ST_ACTIVE) begin
        b              = it.adc_sample[11:4];
        r.sample_taken = 1'b1;
        r.sample_byte  = b;
        vol_now        = (b >= VOL_CENTER) ? b - VOL_CENTER : VOL_CENTER - b;
        if (vol_now > vol_peak)
          vol_peak = vol_now;
        fill_cnt   = fill_cnt + 10'd1;
        sample_cnt = sample_cnt + 32'd1;
        if (fill_cnt >= BUFFER_BYTES) begin
          r.block_full = 1'b1;
          fill_cnt     = '0;
        end
        elapsed_ms = it.now_ms - start_ms;
        // Overlong take: the sample still counts, then the take ends.
        if (elapsed_ms > settings.max_duration_ms)
          r.event_res = close_take(it.now_ms, left);
      end
      MODE_SPEED: if (settings.auto_record_enable) begin
        cur = it.speed_valid ? it.speed_tenths : 12'd0;
        if (rec_now == ST_IDLE || rec_now == ST_STOPPED) begin
          if (cur >= settings.start_speed_tenths)
            r.event_res = open_take(it.now_ms, it.free_bytes);
        end else if (rec_now == ST_ACTIVE) begin
          if (cur < settings.stop_speed_tenths) begin
            lapse = it.now_ms - low_since_ms;
            if (!stop_armed) begin
              stop_armed   = 1'b1;
              low_since_ms = it.now_ms;
            end else if (lapse > settings.stop_hold_ms) begin
              r.event_res = close_take(it.now_ms, left);
            end
          end else begin
            stop_armed = 1'b0;
          end
        end
      end
      MODE_START:  r.event_res = open_take(it.now_ms, it.free_bytes);
      MODE_STOP:   r.event_res = close_take(it.now_ms, left);
      MODE_PAUSE:  if (rec_now == ST_ACTIVE) rec_now = ST_PAUSED;
      MODE_RESUME: if (rec_now == ST_PAUSED) rec_now = ST_ACTIVE;
      default: ;
    endcase
    r.rec_status     = rec_now;
    r.leftover_count = left;
    r.volume_level   = vol_now;
    r.volume_max     = vol_peak;
    r.sample_count   = sample_cnt;
    r.take_ms        = elapsed_ms;
    r.error_flag     = refused;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Random item source. Looks at the shadow state so most items drive real
  // recordings: starts from idle, mostly samples while active, resumes when
  // paused. The rest is noise the block must shrug off.
  // ---------------------------------------------------------------------------
  function automatic item_t next_item();
    item_t it;
    int    r;
    logic [23:0] floor_b;
    floor_b = settings.min_free_bytes;

    // Bias converter values toward the rails and the mid-scale boundary.
    case ($urandom_range(0, 11))
      0:       it.adc_sample = 12'h000;
      1:       it.adc_sample = 12'hFFF;
      2:       it.adc_sample = 12'h800;
      3:       it.adc_sample = 12'h7FF;
      default: it.adc_sample = 12'($urandom_range(0, 4095));
    endcase

    // Land speeds on both sides of each threshold.
    it.speed_valid = ($urandom_range(0, 7) != 0);
    case ($urandom_range(0, 7))
      0:       it.speed_tenths = settings.start_speed_tenths - 12'd1;
      1:       it.speed_tenths = settings.start_speed_tenths;
      2:       it.speed_tenths = settings.stop_speed_tenths - 12'd1;
      3:       it.speed_tenths = settings.stop_speed_tenths;
      4:       it.speed_tenths = 12'hFFF;
      5:       it.speed_tenths = 12'h000;
      default: it.speed_tenths = 12'($urandom_range(0, 4095));
    endcase

    // Mostly enough storage; sometimes below or right at the floor.
    case ($urandom_range(0, 9))
      0: it.free_bytes = (floor_b == 0) ? 24'($urandom_range(0, 24'hFFFFFF))
                                        : 24'($urandom_range(0, floor_b - 24'd1));
      1: it.free_bytes = floor_b;
      default: it.free_bytes = 24'($urandom_range(floor_b, 24'hFFFFFF));
    endcase

    // Advance time; now and then jump anywhere to exercise the wrap.
    t_ms = t_ms + $urandom_range(0, dt_max);
    if ($urandom_range(0, 63) == 0)
      t_ms = $urandom();
    it.now_ms = t_ms;

    r = $urandom_range(0, 99);
    case (rec_now)
      ST_ACTIVE: begin
        if (r < sample_pct)
          it.mode = MODE_SAMPLE;
        else if (r < sample_pct + stop_pct)
          it.mode = MODE_STOP;
        else begin
          case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: it.mode = MODE_SPEED;
            5:             it.mode = MODE_PAUSE;
            6:             it.mode = MODE_START;
            7:             it.mode = MODE_RESUME;
            8:             it.mode = MODE_SPARE6;
            default:       it.mode = MODE_SPARE7;
          endcase
        end
      end
      ST_PAUSED: begin
        if (r < 40)
          it.mode = MODE_RESUME;
        else if (r < 40 + 3 * stop_pct)
          it.mode = MODE_STOP;
        else begin
          case ($urandom_range(0, 5))
            0:       it.mode = MODE_SAMPLE;
            1:       it.mode = MODE_SPEED;
            2:       it.mode = MODE_START;
            3:       it.mode = MODE_PAUSE;
            4:       it.mode = MODE_SPARE6;
            default: it.mode = MODE_SPARE7;
          endcase
        end
      end
      default: begin
        if (r < 40)
          it.mode = MODE_START;
        else if (r < 80)
          it.mode = MODE_SPEED;
        else
          it.mode = 3'($urandom_range(0, 7));
      end
    endcase
    return it;
  endfunction

  // ---------------------------------------------------------------------------
  // Directed items at reset settings (stop delay 30 s, max take 1 h, floor
  // 50000 bytes, start at 10.0 km/h, stop below 5.0 km/h). State and event are
  // spelled out where they are obvious; everything else comes from the shadow.
  // ---------------------------------------------------------------------------
  typedef struct packed {
    item_t      it;
    logic       typed;
    rec_state_t st;
    event_t     ev;
  } step_row_t;

  localparam step_row_t PLAN [0:24] = '{
    // commands with nothing recording are no-ops
    '{'{MODE_SAMPLE, 12'hFFF, 1'b0, 12'd0,   32'd0,     24'd0},      1'b1, ST_IDLE, EV_NONE},
    '{'{MODE_PAUSE,  12'h000, 1'b0, 12'd0,   32'd1,     24'd0},      1'b1, ST_IDLE, EV_NONE},
    '{'{MODE_STOP,   12'h000, 1'b0, 12'd0,   32'd2,     24'd0},      1'b1, ST_IDLE, EV_NONE},
    // one byte short of the storage floor
    '{'{MODE_START,  12'h000, 1'b0, 12'd0,   32'd5,     24'd49999},  1'b1, ST_IDLE, EV_REFUSED},
    // invalid reading counts as standstill
    '{'{MODE_SPEED,  12'h000, 1'b0, 12'hFFF, 32'd8,     24'hFFFFFF}, 1'b1, ST_IDLE, EV_NONE},
    // exactly at start speed and exactly at the floor
    '{'{MODE_SPEED,  12'h000, 1'b1, 12'd100, 32'd10,    24'd50000},  1'b1, ST_ACTIVE, EV_STARTED},
    // volume at both rails and around the center
    '{'{MODE_SAMPLE, 12'h000, 1'b0, 12'd0,   32'd20,    24'd0},      1'b0, ST_IDLE, EV_NONE},
    '{'{MODE_SAMPLE, 12'hFFF, 1'b0, 12'd0,   32'd21,    24'd0},      1'b0, ST_IDLE, EV_NONE},
    '{'{MODE_SAMPLE, 12'h800, 1'b0, 12'd0,   32'd22,    24'd0},      1'b0, ST_IDLE, EV_NONE},
    '{'{MODE_SAMPLE, 12'h7FF, 1'b0, 12'd0,   32'd23,    24'd0},      1'b0, ST_IDLE, EV_NONE},
    // start while already recording
    '{'{MODE_START,  12'h000, 1'b0, 12'd0,   32'd30,    24'hFFFFFF}, 1'b1, ST_ACTIVE, EV_NONE},
    // arm the stop delay, sit exactly on it, then disarm at the threshold
    '{'{MODE_SPEED,  12'h000, 1'b1, 12'd49,  32'd100,   24'd0},      1'b0, ST_IDLE, EV_NONE},
    '{'{MODE_SPEED,  12'h000, 1'b1, 12'd49,  32'd30100, 24'd0},      1'b0, ST_IDLE, EV_NONE},
    '{'{MODE_SPEED,  12'h000, 1'b1, 12'd50,  32'd30150, 24'd0},      1'b0, ST_IDLE, EV_NONE},
    // re-arm, then exceed the delay by one
    '{'{MODE_SPEED,  12'h000, 1'b1, 12'd0,   32'd30200, 24'd0},      1'b0, ST_IDLE, EV_NONE},
    '{'{MODE_SPEED,  12'h000, 1'b1, 12'd0,   32'd60201, 24'd0},      1'b1, ST_STOPPED, EV_STOPPED},
    // unused modes
    '{'{MODE_SPARE6, 12'hFFF, 1'b1, 12'hFFF, 32'hFFFFFFFF, 24'hFFFFFF}, 1'b1, ST_STOPPED, EV_NONE},
    '{'{MODE_SPARE7, 12'h000, 1'b0, 12'd0,   32'd0,     24'd0},      1'b1, ST_STOPPED, EV_NONE},
    // start just before the time wrap
    '{'{MODE_START,  12'h000, 1'b0, 12'd0,   32'hFFFFFF00, 24'hFFFFFF}, 1'b1, ST_ACTIVE, EV_STARTED},
    '{'{MODE_PAUSE,  12'h000, 1'b0, 12'd0,   32'hFFFFFF10, 24'd0},   1'b1, ST_PAUSED, EV_NONE},
    // speed checks are ignored while paused
    '{'{MODE_SPEED,  12'h000, 1'b1, 12'hFFF, 32'hFFFFFF20, 24'd0},   1'b1, ST_PAUSED, EV_NONE},
    '{'{MODE_RESUME, 12'h000, 1'b0, 12'd0,   32'hFFFFFF30, 24'd0},   1'b1, ST_ACTIVE, EV_NONE},
    '{'{MODE_PAUSE,  12'h000, 1'b0, 12'd0,   32'hFFFFFF40, 24'd0},   1'b1, ST_PAUSED, EV_NONE},
    // start from paused opens a new take
    '{'{MODE_START,  12'h000, 1'b0, 12'd0,   32'hFFFFFF80, 24'd50000}, 1'b1, ST_ACTIVE, EV_STARTED},
    // one past max duration across the wrap: sample kept, take ends
    '{'{MODE_SAMPLE, 12'hABC, 1'b0, 12'd0,   32'd3599873, 24'd0},    1'b1, ST_STOPPED, EV_STOPPED}
  };

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: %s got %0h, expected %0h", $time, what, got, want);
    mismatches++;
  endtask

  task automatic check_report(input result_t got, input result_t want);
    if (got.rec_status !== want.rec_status)
      report_mismatch("rec_status", 32'(got.rec_status), 32'(want.rec_status));
    if (got.event_res !== want.event_res)
      report_mismatch("event_res", 32'(got.event_res), 32'(want.event_res));
    if (got.sample_taken !== want.sample_taken)
      report_mismatch("sample_taken", 32'(got.sample_taken), 32'(want.sample_taken));
    if (got.sample_byte !== want.sample_byte)
      report_mismatch("sample_byte", 32'(got.sample_byte), 32'(want.sample_byte));
    if (got.block_full !== want.block_full)
      report_mismatch("block_full", 32'(got.block_full), 32'(want.block_full));
    if (got.leftover_count !== want.leftover_count)
      report_mismatch("leftover_count", 32'(got.leftover_count),
                      32'(want.leftover_count));
    if (got.volume_level !== want.volume_level)
      report_mismatch("volume_level", 32'(got.volume_level), 32'(want.volume_level));
    if (got.volume_max !== want.volume_max)
      report_mismatch("volume_max", 32'(got.volume_max), 32'(want.volume_max));
    if (got.sample_count !== want.sample_count)
      report_mismatch("sample_count", got.sample_count, want.sample_count);
    if (got.take_ms !== want.take_ms)
      report_mismatch("take_ms", got.take_ms, want.take_ms);
    if (got.error_flag !== want.error_flag)
      report_mismatch("error_flag", 32'(got.error_flag), 32'(want.error_flag));
  endtask

  // Compare every report the block hands over against the oldest one owed.
  always @(posedge clk) begin
    result_t got;
    if (!rst && out_valid && !out_stall) begin
      got = {rec_status, event_res, sample_taken, sample_byte, block_full,
             leftover_count, volume_level, volume_max, sample_count,
             take_ms, error_flag};
      if (status_due.size() == 0)
        report_mismatch("report with none pending", 32'(got.rec_status), '0);
      else
        check_report(got, status_due.pop_front());
    end
  end

  // Watchdog: count cycles in which no item moves on either channel.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Result side: hold off for a random number of cycles before taking each
  // item, with calm stretches where every item is taken at once.
  // ---------------------------------------------------------------------------
  initial begin
    int hold;
    out_stall = 1'b0;
    @(posedge clk);
    forever begin
      if ($urandom_range(0, 31) == 0)
        rx_calm = !rx_calm;
      hold = rx_calm ? 0 : $urandom_range(0, 16);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // ---------------------------------------------------------------------------
  // Item side
  // ---------------------------------------------------------------------------

  // Offer one item after a random gap, hold it until taken, then predict.
  // Returns on the edge that accepted the item.
  task automatic send_item(input item_t it, input logic typed, input rec_state_t st,
                           input event_t ev);
    int      gap;
    result_t want;
    if ($urandom_range(0, 31) == 0)
      tx_calm = !tx_calm;
    gap = tx_calm ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    mode         <= it.mode;
    adc_sample   <= it.adc_sample;
    speed_valid  <= it.speed_valid;
    speed_tenths <= it.speed_tenths;
    now_ms       <= it.now_ms;
    free_bytes   <= it.free_bytes;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    want = recorder_step(it);
    // Rows with a hand-written outcome override state and event.
    if (typed) begin
      want.rec_status = st;
      want.event_res  = ev;
    end
    status_due.push_back(want);
  endtask

  // Drop valid and wait until every owed report has arrived.
  task automatic settle();
    in_valid <= 1'b0;
    while (status_due.size() != 0) @(posedge clk);
  endtask

  // Leaves the write strobe high so back-to-back writes need one assignment per edge.
  task automatic write_reg(input cfg_index_t idx, input logic [31:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  // Write all six registers, with junk above the narrow fields.
  task automatic apply_settings(input cfg_t c);
    logic [31:0] noise;
    noise = $urandom();
    write_reg(CFG_AUTO_ENABLE, {noise[31:1], c.auto_record_enable});
    write_reg(CFG_START_SPEED, {noise[31:12], c.start_speed_tenths});
    write_reg(CFG_STOP_SPEED,  {noise[19:0], c.stop_speed_tenths});
    write_reg(CFG_STOP_DELAY,  c.stop_hold_ms);
    write_reg(CFG_MAX_DUR,     c.max_duration_ms);
    write_reg(CFG_MIN_FREE,    {noise[7:0], c.min_free_bytes});
    cfg_write <= 1'b0;
    settings = c;
  endtask

  initial begin
    cfg_t c;
    int   quota;

    rst          = 1'b1;
    in_valid     = 1'b0;
    mode         = MODE_SAMPLE;
    adc_sample   = '0;
    speed_valid  = 1'b0;
    speed_tenths = '0;
    now_ms       = '0;
    free_bytes   = '0;
    cfg_write    = 1'b0;
    cfg_index    = CFG_AUTO_ENABLE;
    cfg_data     = '0;
    tx_calm      = 1'b0;
    t_ms         = '0;
    shadow_reset();

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed items at the reset settings.
    foreach (PLAN[i])
      send_item(PLAN[i].it, PLAN[i].typed, PLAN[i].st, PLAN[i].ev);
    settle();

    // Random phases, each under its own register settings.
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: begin
          // short delays and takes so automatic and overlong stops happen often
          c = '{1'b1, 12'd100, 12'd50, 32'd200, 32'd2000, 24'd1000};
          quota = 90; sample_pct = 60; stop_pct = 3; dt_max = 60;
        end
        1: begin
          // top of every numeric range, auto-record off; long takes to fill the buffer and wrap it
          c = '{1'b0, 12'hFFF, 12'hFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 24'hFFFFFF};
          quota = 560; sample_pct = 95; stop_pct = 0; dt_max = 1000;
        end
        2: begin
          // near the bottom of every range: any speed starts, takes end after 1 ms
          c = '{1'b1, 12'd0, 12'd0, 32'd0, 32'd1, 24'd0};
          quota = 80; sample_pct = 60; stop_pct = 3; dt_max = 3;
        end
        5: begin
          // back to the reset values, written explicitly
          c = '{RST_AUTO_ENABLE, RST_START_SPEED, RST_STOP_SPEED,
                RST_STOP_DELAY, RST_MAX_DUR, RST_MIN_FREE};
          quota = 80; sample_pct = 60; stop_pct = 3; dt_max = 4000;
        end
        default: begin
          c.auto_record_enable = 1'($urandom_range(0, 1));
          c.start_speed_tenths = 12'($urandom_range(0, 300));
          c.stop_speed_tenths  = 12'($urandom_range(0, 300));
          c.stop_hold_ms       = 32'($urandom_range(0, 2000));
          c.max_duration_ms    = 32'($urandom_range(1, 20000));
          c.min_free_bytes     = 24'($urandom_range(0, 24'hFFFFFF));
          quota = 80; sample_pct = 55; stop_pct = 4; dt_max = 150;
        end
      endcase
      apply_settings(c);
      for (int k = 0; k < quota; k++) begin
        send_item(next_item(), 1'b0, ST_IDLE, EV_NONE);
        // Occasionally hold the sender until the block has caught up.
        if ($urandom_range(0, 63) == 0)
          settle();
      end
      settle();
    end

    // Let anything stray arrive before the final count.
    repeat (4) @(posedge clk);
    if (mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
